>>> design/mhpq_pkg.sv
// ============================================================================
// mhpq_pkg
// Shared types and constants for the max-heap priority queue.
// ============================================================================
package mhpq_pkg;

  // Default heap capacity
  localparam int unsigned CAPACITY_DEF = 64;

  // Field widths
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned M_TDATA_W   = 40;

  // Operation carried on s_axis_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Result status carried on m_axis_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_RD0,
    S_RM_RD1,
    S_RM_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } state_e;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_UP_RD,
    CMD_UP_CMP,
    CMD_RM_RD0,
    CMD_RM_RD1,
    CMD_RM_LAST,
    CMD_DN_RDL,
    CMD_DN_RDR,
    CMD_DN_CMP,
    CMD_PUSH
  } cmd_e;

  // Datapath status toward the controller
  typedef struct packed {
    logic in_remove;  // beat on the input asks for a remove
    logic full;       // heap holds CAPACITY entries
    logic empty;      // heap holds no entry
    logic at_root;    // hole is at the root
    logic no_left;    // hole has no left child
    logic up_gt;      // moving value beats its parent
    logic dn_gt;      // chosen child beats the moving value
    logic out_free;   // output register can take a result
  } dp_stat_t;

endpackage

>>> design/mhpq_ram.sv
// ============================================================================
// mhpq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mhpq_ctrl.sv
// ============================================================================
// mhpq_ctrl
// Sequencer for insert (sift up) and remove (sift down) operations.
// ============================================================================
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output cmd_e     cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.in_remove) begin
            state_d = stat_i.empty ? S_DONE : S_RM_RD0;
          end else begin
            state_d = stat_i.full ? S_DONE : S_UP_RD;
          end
        end
      end
      S_UP_RD:   state_d = stat_i.at_root ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_d = stat_i.up_gt ? S_UP_RD : S_DONE;
      S_RM_RD0:  state_d = S_RM_RD1;
      S_RM_RD1:  state_d = S_RM_LAST;
      S_RM_LAST: state_d = S_DN_RDL;
      S_DN_RDL:  state_d = stat_i.no_left ? S_DONE : S_DN_RDR;
      S_DN_RDR:  state_d = S_DN_CMP;
      S_DN_CMP:  state_d = stat_i.dn_gt ? S_DN_RDL : S_DONE;
      S_DONE:    state_d = stat_i.out_free ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o      = in_valid_i ? CMD_LOAD : CMD_NONE;
      end
      S_UP_RD:   cmd_o = CMD_UP_RD;
      S_UP_CMP:  cmd_o = CMD_UP_CMP;
      S_RM_RD0:  cmd_o = CMD_RM_RD0;
      S_RM_RD1:  cmd_o = CMD_RM_RD1;
      S_RM_LAST: cmd_o = CMD_RM_LAST;
      S_DN_RDL:  cmd_o = CMD_DN_RDL;
      S_DN_RDR:  cmd_o = CMD_DN_RDR;
      S_DN_CMP:  cmd_o = CMD_DN_CMP;
      S_DONE:    cmd_o = stat_i.out_free ? CMD_PUSH : CMD_NONE;
      default:   cmd_o = CMD_NONE;
    endcase
  end

endmodule

>>> design/mhpq_dp.sv
// ============================================================================
// mhpq_dp
// Heap datapath: heap RAM, count, hole position, moving value, result reg.
// ============================================================================
module mhpq_dp import mhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_e                   cmd_i,
  output dp_stat_t               stat_o,
  input  logic [VALUE_W-1:0]     in_value_i,
  input  logic                   in_op_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_W-1:0]     out_max_o,
  output logic [COUNT_OUT_W-1:0] out_count_o,
  output logic [STATUS_W-1:0]    out_status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = PW + 1;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  // state and working registers
  logic [PW-1:0]               count_q;
  logic [PW-1:0]               pos_q;     // 1-based hole position
  logic signed [VALUE_W-1:0]   x_q;       // value being sifted
  logic signed [VALUE_W-1:0]   lval_q;    // left child value
  logic [VALUE_W-1:0]          maxv_q;
  status_e                     status_q;

  // result register
  logic                   m_valid_q;
  logic [VALUE_W-1:0]     m_max_q;
  logic [COUNT_OUT_W-1:0] m_cnt_q;
  status_e                m_status_q;

  // RAM port signals
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [VALUE_W-1:0]        wdata;
  logic [AW-1:0]             raddr;
  logic signed [VALUE_W-1:0] rdata;

  // tree arithmetic
  logic [LW-1:0]             left;
  logic [PW-1:0]             parent;
  logic                      has_right;
  logic                      pick_right;
  logic signed [VALUE_W-1:0] pick_val;
  logic [LW-1:0]             pick_pos;
  logic                      up_gt;
  logic                      dn_gt;
  logic                      full;
  logic                      empty;
  logic                      out_free;

  mhpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // compare and child selection
  always_comb begin
    left       = {pos_q, 1'b0};
    parent     = pos_q >> 1;
    has_right  = left < {1'b0, count_q};
    pick_right = has_right && !(lval_q > rdata);  // right child wins ties
    pick_val   = pick_right ? rdata : lval_q;
    pick_pos   = pick_right ? left + LW'(1) : left;
    up_gt      = x_q > rdata;
    dn_gt      = pick_val > x_q;
    full       = count_q == CAP_P;
    empty      = count_q == '0;
    out_free   = !m_valid_q || out_ready_i;
  end

  always_comb begin
    stat_o.in_remove = (in_op_i == OP_REMOVE);
    stat_o.full      = full;
    stat_o.empty     = empty;
    stat_o.at_root   = pos_q == PW'(1);
    stat_o.no_left   = left > {1'b0, count_q};
    stat_o.up_gt     = up_gt;
    stat_o.dn_gt     = dn_gt;
    stat_o.out_free  = out_free;
  end

  // RAM addressing
  always_comb begin
    we    = 1'b0;
    waddr = AW'(pos_q - PW'(1));
    wdata = x_q;
    raddr = '0;
    case (cmd_i)
      CMD_UP_RD: begin
        if (pos_q == PW'(1)) begin
          we = 1'b1;
        end else begin
          raddr = AW'(parent - PW'(1));
        end
      end
      CMD_UP_CMP: begin
        we    = 1'b1;
        wdata = up_gt ? rdata : x_q;
      end
      CMD_RM_RD0: raddr = '0;
      CMD_RM_RD1: raddr = AW'(count_q);
      CMD_DN_RDL: begin
        if (left > {1'b0, count_q}) begin
          we = 1'b1;
        end else begin
          raddr = AW'(left - LW'(1));
        end
      end
      CMD_DN_RDR: raddr = AW'(left);
      CMD_DN_CMP: begin
        we    = 1'b1;
        wdata = dn_gt ? pick_val : x_q;
      end
      default: ;
    endcase
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i == CMD_LOAD) begin
      if (in_op_i == OP_INSERT) begin
        if (!full) count_q <= count_q + PW'(1);
      end else begin
        if (!empty) count_q <= count_q - PW'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        x_q    <= in_value_i;
        maxv_q <= '0;
        if (in_op_i == OP_INSERT) begin
          status_q <= full ? ST_FULL : ST_OK;
          pos_q    <= count_q + PW'(1);
        end else begin
          status_q <= empty ? ST_EMPTY : ST_OK;
          pos_q    <= PW'(1);
        end
      end
      CMD_UP_CMP:  if (up_gt) pos_q <= parent;
      CMD_RM_RD1:  maxv_q <= rdata;
      CMD_RM_LAST: x_q <= rdata;
      CMD_DN_RDR:  lval_q <= rdata;
      CMD_DN_CMP:  if (dn_gt) pos_q <= PW'(pick_pos);
      default: ;
    endcase
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i == CMD_PUSH) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_PUSH) begin
      m_max_q    <= maxv_q;
      m_cnt_q    <= COUNT_OUT_W'(count_q);
      m_status_q <= status_q;
    end
  end

  assign out_valid_o  = m_valid_q;
  assign out_max_o    = m_max_q;
  assign out_count_o  = m_cnt_q;
  assign out_status_o = m_status_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_P)
    else $error("entry count above capacity");

  a_remove_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_LOAD) && (in_op_i == OP_REMOVE) && !empty
    |=> count_q == $past(count_q) - PW'(1))
    else $error("remove did not decrement count");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_status_q == ST_EMPTY) |-> (m_max_q == '0) && (m_cnt_q == '0))
    else $error("empty result carries data");

endmodule

>>> design/max_heap_priority_queue_top.sv
// Operation: insert loads the beat, then per level climbed reads the parent and compares;
//   remove reads root and last entry, then per level reads both children and compares;
//   rejected beats go straight to the result; up to log2(CAPACITY) levels.
// Throughput: one operation at a time; next beat accepted once the result is parked
//   in the output register.
// Reset: rst_ni clears the entry count and control; heap RAM content is not cleared.
// ============================================================================
// max_heap_priority_queue_top
// Bounded binary max-heap of signed 32-bit values with insert / remove-max.
// ============================================================================
module max_heap_priority_queue_top import mhpq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] value
  input  logic [0:0]           s_axis_tuser,  // [0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] max_value, [38:32] entry_count_out
  output logic [STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);

  cmd_e     cmd;
  dp_stat_t stat;

  logic [VALUE_W-1:0]     out_max;
  logic [COUNT_OUT_W-1:0] out_count;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_value_i   (s_axis_tdata[VALUE_W-1:0]),
    .in_op_i      (s_axis_tuser[0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_max_o    (out_max),
    .out_count_o  (out_count),
    .out_status_o (m_axis_tuser)
  );

  // pack result beat, zero pad to whole bytes
  assign m_axis_tdata = {{(M_TDATA_W - VALUE_W - COUNT_OUT_W){1'b0}}, out_count, out_max};

endmodule
